// ===== rtl/core/ism_pkg.sv =====
package ism_pkg;

    localparam int DATA_W            = 32;
    localparam int MODE_W            = 3;
    localparam int STATUS_W          = 2;
    localparam int DEF_STACK_DEPTH   = 32;

    // opcodes carried on s_tuser
    localparam logic [MODE_W-1:0] MODE_PUSH      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PRINT_ALL = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PRINT_TOP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SWAP      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ADD       = 3'd5;
    localparam logic [MODE_W-1:0] MODE_NOP       = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    // write address select
    localparam logic [1:0] WA_TOP = 2'd0;  // first free slot
    localparam logic [1:0] WA_N1  = 2'd1;  // top entry
    localparam logic [1:0] WA_N2  = 2'd2;  // second entry

    // write data select
    localparam logic [1:0] WD_PUSH = 2'd0;
    localparam logic [1:0] WD_RDA  = 2'd1;
    localparam logic [1:0] WD_RDB  = 2'd2;
    localparam logic [1:0] WD_SUM  = 2'd3;

    typedef struct packed {
        logic                accept;
        logic                rd_ptr;
        logic                wr_en;
        logic [1:0]          wr_addr_sel;
        logic [1:0]          wr_data_sel;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                ptr_dec;
        logic                emit;
        logic                emit_value;
        logic [STATUS_W-1:0] emit_status;
        logic                emit_last;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic short_stack;
        logic full;
        logic ptr_zero;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/core/ism_ctrl.sv =====
module ism_ctrl import ism_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [MODE_W-1:0] s_mode,
    input  sts_t              sts,
    output cmd_t              cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SWAP2 = 3'd2;
    localparam logic [2:0] S_DREAD = 3'd3;
    localparam logic [2:0] S_DEMIT = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    mode_next  = s_mode;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = ST_OK;
                    state_next      = S_IDLE;
                    case (mode_reg)
                        MODE_PUSH: begin
                            if (sts.full) begin
                                cmd.emit_status = ST_OVERFLOW;
                            end else begin
                                cmd.wr_en       = 1'b1;
                                cmd.wr_addr_sel = WA_TOP;
                                cmd.wr_data_sel = WD_PUSH;
                                cmd.cnt_inc     = 1'b1;
                            end
                        end
                        MODE_PRINT_ALL: begin
                            // top entry already read at accept, walk down from it
                            if (!sts.empty) begin
                                cmd.emit   = 1'b0;
                                state_next = S_DEMIT;
                            end
                        end
                        MODE_PRINT_TOP: begin
                            if (sts.empty) begin
                                cmd.emit_status = ST_EMPTY;
                            end else begin
                                cmd.emit_value = 1'b1;
                            end
                        end
                        MODE_POP: begin
                            if (sts.empty) begin
                                cmd.emit_status = ST_EMPTY;
                            end else begin
                                cmd.cnt_dec = 1'b1;
                            end
                        end
                        MODE_SWAP: begin
                            if (sts.short_stack) begin
                                cmd.emit_status = ST_SHORT;
                            end else begin
                                cmd.wr_en       = 1'b1;
                                cmd.wr_addr_sel = WA_N1;
                                cmd.wr_data_sel = WD_RDB;
                                state_next      = S_SWAP2;
                            end
                        end
                        MODE_ADD: begin
                            if (sts.short_stack) begin
                                cmd.emit_status = ST_SHORT;
                            end else begin
                                cmd.wr_en       = 1'b1;
                                cmd.wr_addr_sel = WA_N2;
                                cmd.wr_data_sel = WD_SUM;
                                cmd.cnt_dec     = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SWAP2: begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = WA_N2;
                cmd.wr_data_sel = WD_RDA;
                state_next      = S_IDLE;
            end
            S_DREAD: begin
                cmd.rd_ptr = 1'b1;
                state_next = S_DEMIT;
            end
            S_DEMIT: begin
                if (sts.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_value  = 1'b1;
                    cmd.emit_status = ST_OK;
                    cmd.emit_last   = sts.ptr_zero;
                    if (sts.ptr_zero) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.ptr_dec = 1'b1;
                        state_next  = S_DREAD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_NOP;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

// ===== rtl/core/ism_dp.sv =====
module ism_dp import ism_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [DATA_W-1:0]   s_push_value,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_out_value,
    output logic                m_value_valid,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_last
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [DATA_W-1:0] push_reg;
    logic [DATA_W-1:0] rd_a_reg, rd_b_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_vv_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic              out_last_reg;

    logic [CW-1:0]     count_m1, count_m2;
    logic [AW-1:0]     addr_top, addr_n1, addr_n2, rd_addr_a;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              out_free;

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign addr_top = count_reg[AW-1:0];
    assign addr_n1  = count_m1[AW-1:0];
    assign addr_n2  = count_m2[AW-1:0];
    assign rd_addr_a = cmd.rd_ptr ? ptr_reg : addr_n1;

    always_comb begin
        case (cmd.wr_addr_sel)
            WA_TOP:  wr_addr = addr_top;
            WA_N1:   wr_addr = addr_n1;
            WA_N2:   wr_addr = addr_n2;
            default: wr_addr = addr_n2;
        endcase
        case (cmd.wr_data_sel)
            WD_PUSH: wr_data = push_reg;
            WD_RDA:  wr_data = rd_a_reg;
            WD_RDB:  wr_data = rd_b_reg;
            WD_SUM:  wr_data = rd_a_reg + rd_b_reg;
            default: wr_data = push_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (cmd.accept || cmd.rd_ptr) begin
            rd_a_reg <= stack_mem[rd_addr_a];
        end
        if (cmd.accept) begin
            rd_b_reg <= stack_mem[addr_n2];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_m1;
        end
        ptr_next = ptr_reg;
        if (cmd.accept) begin
            ptr_next = addr_n1;
        end else if (cmd.ptr_dec) begin
            ptr_next = ptr_reg - AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        if (cmd.accept) begin
            push_reg <= s_push_value;
        end
    end

    // one-deep output register
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_value_reg  <= cmd.emit_value ? rd_a_reg : '0;
            out_vv_reg     <= cmd.emit_value;
            out_status_reg <= cmd.emit_status;
            out_last_reg   <= cmd.emit_last;
        end
    end

    assign sts.empty       = (count_reg == '0);
    assign sts.short_stack = (count_reg < CW'(2));
    assign sts.full        = (count_reg == CW'(STACK_DEPTH));
    assign sts.ptr_zero    = (ptr_reg == '0);
    assign sts.out_free    = out_free;

    assign m_tvalid      = out_valid_reg;
    assign m_out_value   = out_value_reg;
    assign m_value_valid = out_vv_reg;
    assign m_status      = out_status_reg;
    assign m_last        = out_last_reg;

endmodule

// ===== rtl/core/integer_stack_machine_top.sv =====
// Bounded LIFO stack of 32-bit signed integers, one opcode per request on
// s_tuser (push, print all, print top, pop, swap, add, nop) with the push
// value on s_tdata. Every request returns one result, except print all on
// a non-empty stack, which returns every entry from top to bottom, last
// marked by m_tlast. Errors (empty, too short, overflow) leave the stack
// untouched and come back in the status field. The stack memory is read
// through a register: a request is taken in the idle state and executed
// in the execute state once the output register is free; swap needs a
// second state for its two memory writes, and print all alternates a
// read state and an emit state down the stack. A result waiting in the
// output register does not block the next request from being taken.
module integer_stack_machine_top import ism_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic signed [DATA_W-1:0] s_tdata,   // push_value
    input  logic [MODE_W-1:0]        s_tuser,   // mode
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [DATA_W-1:0] m_tdata,   // out_value
    output logic [2:0]               m_tuser,   // {status[1:0], value_valid}
    output logic                     m_tlast
);

    cmd_t                cmd;
    sts_t                sts;
    logic [DATA_W-1:0]   out_value;
    logic                value_valid;
    logic [STATUS_W-1:0] status;

    ism_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_mode   (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    ism_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_push_value  (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_out_value   (out_value),
        .m_value_valid (value_valid),
        .m_status      (status),
        .m_last        (m_tlast)
    );

    assign m_tdata = out_value;
    assign m_tuser = {status, value_valid};

    // a taken request is executed before the next one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one executing");

    // error results never carry a stack entry
    a_err_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:1] != ST_OK)) |-> !m_tuser[0])
        else $error("error result flagged with a value");

    // never overwrite a result that has not been taken
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result loaded into occupied output register");

    // push never grows a full stack
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |-> (!sts.full && !cmd.cnt_dec))
        else $error("entry count grown past the stack depth");

endmodule
